### hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Needs a clock and an active-high reset name at each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   `ASSERT_CLK(label, clk, rst, !(cond))

`endif

### hw/rtl/cpsc_pkg.sv
// Package for the charlieplex PWM scanner: request/response structs,
// array geometry constants and the LED index decode. No dependencies.
package cpsc_pkg;

   // PWM ramp length and derived widths
   localparam int PWM_STEPS = 64;
   localparam int RAMP_W    = $clog2(PWM_STEPS);
   localparam int LEVEL_W   = 6;
   localparam int CMP_W     = (RAMP_W > LEVEL_W) ? RAMP_W : LEVEL_W;

   // Array geometry
   localparam int NUM_COLUMNS     = 4;
   localparam int LEDS_PER_COLUMN = 3;
   localparam int COL_W           = 2;
   localparam int POS_W           = 2;
   localparam int LED_IDX_W       = 4;
   localparam int PIN_W           = 5;

   // Request kinds
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   typedef struct packed {
      logic                 req_type;
      logic [LED_IDX_W-1:0] led_index;
      logic [LEVEL_W-1:0]   level_value;
   } cpsc_req_type;

   typedef struct packed {
      logic [PIN_W-1:0] pin_direction;
      logic [PIN_W-1:0] pin_drive;
   } cpsc_rsp_type;

   // Level table write command
   typedef struct packed {
      logic               en;
      logic [COL_W-1:0]   row;
      logic [POS_W-1:0]   pos;
      logic [LEVEL_W-1:0] level;
   } tbl_wr_type;

   // Split an LED index into column and position; indexes above 11 do nothing
   function automatic tbl_wr_type led_decode(input logic [LED_IDX_W-1:0] idx,
                                             input logic [LEVEL_W-1:0]   level);
      tbl_wr_type wr;
      wr.en    = 1'b1;
      wr.row   = '0;
      wr.pos   = '0;
      wr.level = level;
      case (idx)
         4'd0:  begin wr.row = 2'd0; wr.pos = 2'd0; end
         4'd1:  begin wr.row = 2'd0; wr.pos = 2'd1; end
         4'd2:  begin wr.row = 2'd0; wr.pos = 2'd2; end
         4'd3:  begin wr.row = 2'd1; wr.pos = 2'd0; end
         4'd4:  begin wr.row = 2'd1; wr.pos = 2'd1; end
         4'd5:  begin wr.row = 2'd1; wr.pos = 2'd2; end
         4'd6:  begin wr.row = 2'd2; wr.pos = 2'd0; end
         4'd7:  begin wr.row = 2'd2; wr.pos = 2'd1; end
         4'd8:  begin wr.row = 2'd2; wr.pos = 2'd2; end
         4'd9:  begin wr.row = 2'd3; wr.pos = 2'd0; end
         4'd10: begin wr.row = 2'd3; wr.pos = 2'd1; end
         4'd11: begin wr.row = 2'd3; wr.pos = 2'd2; end
         default: wr.en = 1'b0;
      endcase
      return wr;
   endfunction

endpackage

### hw/rtl/cpsc_level_table.sv
// Brightness level table: four rows (one per column) of three levels.
// Depends on cpsc_pkg. Cleared by reset, one row read per cycle.
module cpsc_level_table
   import cpsc_pkg::*;
(
   input  logic                                      clock,
   input  logic                                      reset,
   input  tbl_wr_type                                wr,
   input  logic [COL_W-1:0]                          rd_row,
   output logic [LEDS_PER_COLUMN-1:0][LEVEL_W-1:0]   rd_levels
);

   logic [LEDS_PER_COLUMN-1:0][LEVEL_W-1:0] row_ff [NUM_COLUMNS];

   // Level storage, single write port
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_COLUMNS; r++) begin
            row_ff[r] <= '0;
         end
      end else if (wr.en) begin
         row_ff[wr.row][wr.pos] <= wr.level;
      end
   end

   // Whole row for the active column
   assign rd_levels = row_ff[rd_row];

endmodule

### hw/rtl/cpsc_scan.sv
// Scan state: PWM ramp, active column and lit LEDs, plus the pin encode.
// Depends on cpsc_pkg; reads one row of the level table per tick.
module cpsc_scan
   import cpsc_pkg::*;
(
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      tick_en,
   output logic [COL_W-1:0]                          rd_row,
   input  logic [LEDS_PER_COLUMN-1:0][LEVEL_W-1:0]   rd_levels,
   output cpsc_rsp_type                              pins
);

   localparam logic [RAMP_W-1:0] RAMP_LAST = RAMP_W'(PWM_STEPS - 1);

   logic [RAMP_W-1:0]          ramp_ff, ramp_in;
   logic [COL_W-1:0]           col_ff, col_in;
   logic [NUM_COLUMNS-1:0]     onehot_ff, onehot_in;
   logic [LEDS_PER_COLUMN-1:0] lit_ff, lit_in;
   logic [LEDS_PER_COLUMN-1:0] lit_base, hit;
   logic                       wrap;
   logic [NUM_COLUMNS-1:0]     low_mask, lit_wide, spread;

   // Ramp advance; a wrap selects the next column with all LEDs on
   always_comb begin
      wrap      = (ramp_ff == RAMP_LAST);
      ramp_in   = wrap ? '0 : ramp_ff + 1'b1;
      col_in    = wrap ? col_ff + 1'b1 : col_ff;
      onehot_in = wrap ? (NUM_COLUMNS'(1) << col_in) : onehot_ff;
      lit_base  = wrap ? '1 : lit_ff;
   end

   assign rd_row = col_in;

   // Switch off each LED whose level matches the ramp
   always_comb begin
      for (int k = 0; k < LEDS_PER_COLUMN; k++) begin
         hit[k] = (CMP_W'(rd_levels[k]) == CMP_W'(ramp_in));
      end
      lit_in = lit_base & ~hit;
   end

   // Insert the column pin into the lit bits
   always_comb begin
      low_mask = onehot_in - 1'b1;
      lit_wide = NUM_COLUMNS'(lit_in);
      spread   = (lit_wide & low_mask) | ((lit_wide & ~low_mask) << 1);
      pins.pin_direction = {spread | onehot_in, 1'b0};
      pins.pin_drive     = {spread, 1'b0};
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_ff   <= '0;
         col_ff    <= '0;
         onehot_ff <= '0;
         lit_ff    <= '0;
      end else if (tick_en) begin
         ramp_ff   <= ramp_in;
         col_ff    <= col_in;
         onehot_ff <= onehot_in;
         lit_ff    <= lit_in;
      end
   end

endmodule

### hw/rtl/charlieplex_pwm_scanner_core.sv
// Charlieplex PWM scanner: takes one request per clock, sustained. A request
// sits in the input register while the scan logic works on it; a tick's pin
// words land in the result register as it leaves the input register, so a
// result passes through both registers in turn. Writes load the level table,
// which reset clears at once, and give no result. The only limit on rate is
// the downstream stall: a held result holds the input register.
module charlieplex_pwm_scanner_core
   import cpsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  cpsc_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output cpsc_rsp_type rsp_payload
);

   logic                                    s1_valid_ff, s1_valid_in;
   cpsc_req_type                            s1_req_ff;
   logic                                    rsp_valid_ff, rsp_valid_in;
   cpsc_rsp_type                            rsp_ff;
   logic                                    req_accept, s1_go, tick_en;
   tbl_wr_type                              tbl_wr;
   logic [COL_W-1:0]                        rd_row;
   logic [LEDS_PER_COLUMN-1:0][LEVEL_W-1:0] rd_levels;
   cpsc_rsp_type                            pins;

   // Input register advances when the result register has room (writes always)
   always_comb begin
      s1_go = s1_valid_ff &&
              ((s1_req_ff.req_type == REQ_WRITE) || !rsp_valid_ff || !rsp_stall);
      req_stall   = s1_valid_ff && !s1_go;
      req_accept  = req_valid && !req_stall;
      s1_valid_in = req_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      tick_en     = s1_go && (s1_req_ff.req_type == REQ_TICK);
      rsp_valid_in = tick_en ? 1'b1 : ((rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff);
   end

   // Table write command from the held request
   always_comb begin
      tbl_wr    = led_decode(s1_req_ff.led_index, s1_req_ff.level_value);
      tbl_wr.en = tbl_wr.en && s1_go && (s1_req_ff.req_type == REQ_WRITE);
   end

   cpsc_level_table u_table (
      .clock     (clock),
      .reset     (reset),
      .wr        (tbl_wr),
      .rd_row    (rd_row),
      .rd_levels (rd_levels)
   );

   cpsc_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .tick_en   (tick_en),
      .rd_row    (rd_row),
      .rd_levels (rd_levels),
      .pins      (pins)
   );

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_payload;
      end
      if (tick_en) begin
         rsp_ff <= pins;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### hw/rtl/cpsc_checker.sv
// Port-level checks for the charlieplex PWM scanner, bound to the top level.
// Depends on cpsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cpsc_checker
   import cpsc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input cpsc_rsp_type rsp_payload
);

   logic [PIN_W-1:0] dir_pins, drv_pins;

   assign dir_pins = rsp_payload.pin_direction;
   assign drv_pins = rsp_payload.pin_drive;

   // A stalled response holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))

   // Requests flow whenever the response side is not holding
   `ASSERT_CLK(a_req_flow, clock, reset, !(rsp_valid && rsp_stall) |-> !req_stall)

   // Driven pins are always enabled, and pin zero is never used
   `ASSERT_NEVER(a_drive_dir, clock, reset, rsp_valid && ((drv_pins & ~dir_pins) != '0 || dir_pins[0]))

   // At most one enabled pin is pulled low: the column pin
   `ASSERT_CLK(a_one_col, clock, reset, rsp_valid |-> $countones(dir_pins & ~drv_pins) <= 1)

endmodule

bind charlieplex_pwm_scanner_core cpsc_checker u_checker (.*);
